// ----- rtl/pidc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PID controller package
// Widths, register indexes, flag bits, item types and saturation helper.
// ----------------------------------------------------------------------------
package pidc_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned FracBits  = 16;

  // Configuration registers.
  localparam int unsigned CfgCount    = 6;
  localparam int unsigned CfgIdxWidth = $clog2(CfgCount);
  localparam int unsigned FlagWidth   = 4;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgGainProp      = 0,
    CfgGainInteg     = 1,
    CfgGainDeriv     = 2,
    CfgIntegLimitHi  = 3,
    CfgIntegLimitLo  = 4,
    CfgControlFlags  = 5
  } cfg_reg_t;

  // Bit positions inside control_flags.
  localparam int unsigned FlagIncr  = 0;
  localparam int unsigned FlagDeriv = 1;
  localparam int unsigned FlagInteg = 2;
  localparam int unsigned FlagAllow = 3;

  typedef enum logic [1:0] {
    ClampNone = 2'd0,
    ClampHigh = 2'd1,
    ClampLow  = 2'd2
  } clamp_t;

  // Datapath widths.
  localparam int unsigned DeltaWidth  = DataWidth + 2;          // e - 2*e1 + e2
  localparam int unsigned DivWidth    = DeltaWidth + FracBits;  // |delta| * 2^frac
  localparam int unsigned DivCntWidth = $clog2(DivWidth);
  localparam int unsigned MulAWidth   = DataWidth + 1;
  localparam int unsigned ProdWidth   = MulAWidth + DataWidth;
  localparam int unsigned TermWidth   = ProdWidth - FracBits;
  localparam int unsigned AccWidth    = TermWidth + 3;

  typedef logic signed [DataWidth-1:0] word_t;

  typedef struct packed {
    word_t error_sample;
    word_t time_step;
  } in_item_t;

  typedef struct packed {
    word_t      drive_value;
    logic       step_invalid;
    logic [1:0] clamp_status;
  } out_item_t;

  // Saturate a wide signed value to one data word.
  function automatic word_t sat_word(input logic signed [AccWidth-1:0] x);
    logic signed [AccWidth-1:0] hi;
    logic signed [AccWidth-1:0] lo;
    hi = {{(AccWidth-DataWidth+1){1'b0}}, {(DataWidth-1){1'b1}}};
    lo = ~hi;
    if (x > hi) begin
      return hi[DataWidth-1:0];
    end else if (x < lo) begin
      return lo[DataWidth-1:0];
    end else begin
      return x[DataWidth-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// ----- rtl/pid_controller_dual_form_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PID controller core, positional and incremental forms
// One error sample and time step in, one saturated drive value out, computed
// by a bit-serial divider and one shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake               Payload
//   in        input      in_valid / in_ready     in_item  (error_sample, time_step)
//   out       output     out_valid / out_ready   out_item (drive_value, step_invalid,
//                                                          clamp_status)
//   cfg       input      cfg_write               cfg_addr, cfg_data
//
// An item with the derivative term enabled passes through 50 restoring-division
// steps that form (delta * 2^16) / dt one quotient bit per cycle, a step that
// saturates the quotient, three passes of the shared 33x32 multiplier and a
// step that loads the result. With the derivative off the division is skipped;
// an item with dt <= 0 goes straight to the step that loads the result.
// in_ready is high only while the sequencer is idle, and it returns on the edge
// that loads the result, so a new item is accepted only after the previous one
// has been loaded into the output register. A finished result waits in the
// output register, so the next item may be accepted while it is pending; the
// sequencer stalls in its final state if the previous result is still unclaimed.
// Reset is synchronous and restores the sequencer, out_valid, the configuration
// and the controller state; the working registers and out_item are not reset.
//
module pid_controller_dual_form_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  pidc_pkg::in_item_t                    in_item,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output pidc_pkg::out_item_t                   out_item,
  input  logic                                  cfg_write,
  input  logic [pidc_pkg::CfgIdxWidth-1:0]      cfg_addr,
  input  logic [pidc_pkg::DataWidth-1:0]        cfg_data
);
  import pidc_pkg::*;

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    SIdle = 6'b000001,
    SDiv  = 6'b000010,
    SQSat = 6'b000100,
    SMul  = 6'b001000,
    SAcc  = 6'b010000,
    SFin  = 6'b100000
  } state_t;

  // Which product the shared multiplier is working on.
  typedef enum logic [1:0] {
    TermProp  = 2'd0,
    TermInteg = 2'd1,
    TermDeriv = 2'd2
  } term_t;

  state_t state;
  term_t  term_sel;

  // Configuration registers.
  word_t                gain_prop;
  word_t                gain_integ;
  word_t                gain_deriv;
  word_t                limit_hi;
  word_t                limit_lo;
  logic [FlagWidth-1:0] control_flags;

  // Controller state carried from item to item.
  word_t  last_error;
  word_t  error_before_last;
  word_t  integral_sum;
  word_t  last_drive;
  clamp_t clamp_code;

  // Working registers of the item in flight.
  word_t                       err;
  word_t                       dt;
  logic                        step_bad;
  logic                        delta_neg;
  logic [DivWidth-1:0]         div_reg;
  logic [DataWidth-2:0]        rem;
  logic [DivCntWidth-1:0]      div_cnt;
  word_t                       diff;
  logic signed [ProdWidth-1:0] prod;
  logic signed [AccWidth-1:0]  acc;
  word_t                       isum_new;
  clamp_t                      clamp_new;

  logic incr, d_on, i_on, i_allow;
  assign incr    = control_flags[FlagIncr];
  assign d_on    = control_flags[FlagDeriv];
  assign i_on    = control_flags[FlagInteg];
  assign i_allow = control_flags[FlagAllow];

  assign in_ready = (state == SIdle);

  logic accept;
  assign accept = in_valid && in_ready;

  logic out_free;
  assign out_free = !out_valid || out_ready;

  // The result is loaded on this edge.
  logic fin_fire;
  assign fin_fire = (state == SFin) && out_free;

  // The numerator of the derivative: first or second difference of the error.
  logic signed [DeltaWidth-1:0] e_d, e1_d, e2_d, delta;
  logic        [DeltaWidth-1:0] delta_mag;
  logic                         dt_bad;

  always_comb begin
    e_d  = DeltaWidth'(in_item.error_sample);
    e1_d = DeltaWidth'(last_error);
    e2_d = DeltaWidth'(error_before_last);
    if (incr) begin
      delta = e_d - (e1_d <<< 1) + e2_d;
    end else begin
      delta = e_d - e1_d;
    end
    delta_mag = delta[DeltaWidth-1] ? DeltaWidth'(-delta) : DeltaWidth'(delta);
    dt_bad    = in_item.time_step[DataWidth-1] || (in_item.time_step == '0);
  end

  // One restoring-division step: the partial remainder stays below dt.
  logic [DataWidth-1:0] trial;
  logic [DataWidth-1:0] trial_sub;
  logic                 q_bit;

  always_comb begin
    trial     = {rem, div_reg[DivWidth-1]};
    trial_sub = trial - dt;
    q_bit     = (trial >= dt);
  end

  // Saturate the unsigned quotient magnitude with the sign of delta.
  word_t quot_sat;
  logic  q_ovf_pos, q_ovf_neg;

  always_comb begin
    q_ovf_pos = |div_reg[DivWidth-1:DataWidth-1];
    q_ovf_neg = (|div_reg[DivWidth-1:DataWidth]) ||
                (div_reg[DataWidth-1] && (|div_reg[DataWidth-2:0]));
    if (delta_neg) begin
      quot_sat = q_ovf_neg ? {1'b1, {(DataWidth-1){1'b0}}}
                           : word_t'(-div_reg[DataWidth-1:0]);
    end else begin
      quot_sat = q_ovf_pos ? {1'b0, {(DataWidth-1){1'b1}}}
                           : word_t'(div_reg[DataWidth-1:0]);
    end
  end

  // Operands of the shared multiplier.
  logic signed [MulAWidth-1:0] mul_a;
  word_t                       mul_b;
  logic signed [ProdWidth-1:0] mul_full;

  always_comb begin
    unique case (term_sel)
      TermProp: begin
        mul_a = incr ? (MulAWidth'(err) - MulAWidth'(last_error)) : MulAWidth'(err);
        mul_b = gain_prop;
      end
      TermInteg: begin
        mul_a = MulAWidth'(err);
        mul_b = gain_integ;
      end
      TermDeriv: begin
        mul_a = MulAWidth'(diff);
        mul_b = gain_deriv;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_full = mul_a * mul_b;
  end

  // Products are scaled back with floor rounding.
  logic signed [TermWidth-1:0]  term;
  logic signed [TermWidth:0]    cand;
  word_t                        isum_calc;
  clamp_t                       clamp_calc;

  always_comb begin
    term = prod[ProdWidth-1:FracBits];
    cand = (TermWidth+1)'(integral_sum) + (TermWidth+1)'(term);
    isum_calc  = integral_sum;
    clamp_calc = clamp_code;
    if (incr) begin
      isum_calc = i_on ? sat_word(AccWidth'(term)) : '0;
    end else if (i_on && i_allow) begin
      // The high limit is tested first, so it wins when the limits cross.
      if (cand > (TermWidth+1)'(limit_hi)) begin
        isum_calc  = limit_hi;
        clamp_calc = ClampHigh;
      end else if (cand < (TermWidth+1)'(limit_lo)) begin
        isum_calc  = limit_lo;
        clamp_calc = ClampLow;
      end else begin
        isum_calc  = cand[DataWidth-1:0];
        clamp_calc = ClampNone;
      end
    end
  end

  word_t drive_sat;
  assign drive_sat = sat_word(acc);

  // Control, configuration and controller state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= SIdle;
      out_valid         <= 1'b0;
      gain_prop         <= '0;
      gain_integ        <= '0;
      gain_deriv        <= '0;
      limit_hi          <= {1'b0, {(DataWidth-1){1'b1}}};
      limit_lo          <= {1'b1, {(DataWidth-1){1'b0}}};
      control_flags     <= '0;
      last_error        <= '0;
      error_before_last <= '0;
      integral_sum      <= '0;
      last_drive        <= '0;
      clamp_code        <= ClampNone;
    end else begin
      if (cfg_write) begin
        unique case (cfg_reg_t'(cfg_addr))
          CfgGainProp:     gain_prop     <= cfg_data;
          CfgGainInteg:    gain_integ    <= cfg_data;
          CfgGainDeriv:    gain_deriv    <= cfg_data;
          CfgIntegLimitHi: limit_hi      <= cfg_data;
          CfgIntegLimitLo: limit_lo      <= cfg_data;
          CfgControlFlags: control_flags <= cfg_data[FlagWidth-1:0];
          default: ;
        endcase
      end

      // A new result replaces one that is taken on the same edge.
      if (fin_fire) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        SIdle: begin
          if (accept) begin
            if (dt_bad) begin
              state <= SFin;
            end else if (d_on) begin
              state <= SDiv;
            end else begin
              state <= SMul;
            end
          end
        end
        SDiv: begin
          if (div_cnt == '0) begin
            state <= SQSat;
          end
        end
        SQSat: state <= SMul;
        SMul:  state <= SAcc;
        SAcc: begin
          state <= (term_sel == TermDeriv) ? SFin : SMul;
        end
        SFin: begin
          if (out_free) begin
            state <= SIdle;
            if (!step_bad) begin
              last_drive   <= drive_sat;
              integral_sum <= isum_new;
              clamp_code   <= clamp_new;
              last_error   <= err;
              if (incr) begin
                error_before_last <= last_error;
              end
            end
          end
        end
        default: state <= SIdle;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      SIdle: begin
        if (accept) begin
          err       <= in_item.error_sample;
          dt        <= in_item.time_step;
          step_bad  <= dt_bad;
          delta_neg <= delta[DeltaWidth-1];
          div_reg   <= {delta_mag, {FracBits{1'b0}}};
          rem       <= '0;
          div_cnt   <= DivCntWidth'(DivWidth - 1);
          diff      <= '0;
          term_sel  <= TermProp;
        end
      end
      SDiv: begin
        div_reg <= {div_reg[DivWidth-2:0], q_bit};
        rem     <= q_bit ? trial_sub[DataWidth-2:0] : trial[DataWidth-2:0];
        div_cnt <= div_cnt - 1'b1;
      end
      SQSat: diff <= quot_sat;
      SMul:  prod <= mul_full;
      SAcc: begin
        unique case (term_sel)
          TermProp: begin
            acc      <= AccWidth'(term) + (incr ? AccWidth'(last_drive) : '0);
            term_sel <= TermInteg;
          end
          TermInteg: begin
            isum_new  <= isum_calc;
            clamp_new <= clamp_calc;
            term_sel  <= TermDeriv;
          end
          TermDeriv: begin
            acc <= acc + AccWidth'(term) + AccWidth'(isum_new);
          end
          default: ;
        endcase
      end
      SFin: begin
        if (out_free) begin
          if (step_bad) begin
            out_item.drive_value  <= last_drive;
            out_item.step_invalid <= 1'b1;
            out_item.clamp_status <= clamp_code;
          end else begin
            out_item.drive_value  <= drive_sat;
            out_item.step_invalid <= 1'b0;
            out_item.clamp_status <= clamp_new;
          end
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/pidc_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PID controller port checker
// Checks handshake and result behavior seen at the core's ports.
// ----------------------------------------------------------------------------
module pidc_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input pidc_pkg::in_item_t                    in_item,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input pidc_pkg::out_item_t                   out_item,
  input logic                                  cfg_write
);
  import pidc_pkg::*;

  logic in_acc, bad_step;
  assign in_acc   = in_valid && in_ready;
  assign bad_step = in_item.time_step[DataWidth-1] || (in_item.time_step == '0);

  // A pending result holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result item changed or dropped while stalled");

  // The core works on one item at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ready)
    else $error("input accepted while an item is in flight");

  // Clamp status never carries the unused code.
  a_clamp_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.clamp_status == ClampNone ||
                   out_item.clamp_status == ClampHigh ||
                   out_item.clamp_status == ClampLow))
    else $error("clamp status out of range");

  // A non-positive time step is flagged in the result loaded from the final state when the output is free.
  a_bad_step: assert property (@(posedge clk) disable iff (rst)
    in_acc && bad_step ##1 (!out_valid || out_ready) |=>
      out_valid && out_item.step_invalid)
    else $error("invalid time step not flagged");

  // Configuration is never written while an item is in flight.
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_write |-> in_ready)
    else $error("configuration written while busy");

endmodule

bind pid_controller_dual_form_core pidc_checker u_pidc_checker (.*);
`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID controller core testbench
// Drives error samples and time steps through the valid/ready input channel,
// predicts each drive value, invalid-step flag and clamp status in a local
// model of the positional and incremental forms, and checks every output item
// in order while both sides idle at random and the receiver stalls for long.
// ----------------------------------------------------------------------------
module testbench;
  import pidc_pkg::*;

  // Numeric limits of one data word, held in 64 bits for the model.
  localparam longint WordMax    = (longint'(1) << (DataWidth - 1)) - 1;
  localparam longint WordMin    = -WordMax - 1;
  localparam longint FracScale  = longint'(1) << FracBits;
  localparam word_t  TopWord    = word_t'(WordMax);
  localparam word_t  BottomWord = word_t'(WordMin);

  // A quiet stretch this long means the block has hung. It lies well above the
  // slowest item, the long receiver stall (LongHold) and the longest source gap,
  // so this leaves a wide margin.
  localparam int StallLimit = 2500;
  localparam int LongHold   = 400;

  logic      clk;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;
  logic      cfg_write = 1'b0;
  logic [CfgIdxWidth-1:0] cfg_addr = '0;
  logic [DataWidth-1:0]   cfg_data = '0;

  pid_controller_dual_form_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_write (cfg_write),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Controller model. The register copies mirror what has been written to the
  // block; the state copies follow every accepted item.
  // --------------------------------------------------------------------------
  longint         ctl_kp     = 0;
  longint         ctl_ki     = 0;
  longint         ctl_kd     = 0;
  longint         ctl_lim_hi = WordMax;
  longint         ctl_lim_lo = WordMin;
  logic [FlagWidth-1:0] ctl_flags = '0;

  longint prev_err   = 0;
  longint prev_err2  = 0;
  longint integ_acc  = 0;
  longint prev_drive = 0;
  clamp_t clamp_state = ClampNone;

  function automatic longint clip_word(longint x);
    if (x > WordMax) return WordMax;
    if (x < WordMin) return WordMin;
    return x;
  endfunction

  // Fixed-point product, rounded toward minus infinity.
  function automatic longint mul_q(longint a, longint b);
    return (a * b) >>> FracBits;
  endfunction

  // Scaled rate delta / dt, truncated toward zero and clipped to one word.
  // The split into quotient and remainder keeps the scaled dividend in range.
  function automatic longint rate_q(longint delta, longint dt);
    longint q;
    longint r;
    q = delta / dt;
    r = delta % dt;
    if (q > WordMax + 1) q = WordMax + 1;
    if (q < -(WordMax + 1)) q = -(WordMax + 1);
    return clip_word(q * FracScale + (r * FracScale) / dt);
  endfunction

  // One control step: returns the output item and advances the model state.
  function automatic out_item_t compute_drive(in_item_t it);
    longint    e;
    longint    dt;
    longint    slope;
    longint    cand;
    longint    drive;
    out_item_t res;
    e  = it.error_sample;
    dt = it.time_step;
    // A non-positive time step repeats the last drive and leaves all state alone.
    if (dt <= 0) begin
      res.drive_value  = word_t'(prev_drive);
      res.step_invalid = 1'b1;
      res.clamp_status = clamp_state;
      return res;
    end
    if (!ctl_flags[FlagIncr]) begin
      // Positional form. The accumulator only moves when integration is both
      // enabled and allowed, but it always contributes to the drive.
      slope = ctl_flags[FlagDeriv] ? rate_q(e - prev_err, dt) : 0;
      if (ctl_flags[FlagInteg] && ctl_flags[FlagAllow]) begin
        cand = integ_acc + mul_q(e, ctl_ki);
        // With crossed limits the high test is made first and wins.
        if (cand > ctl_lim_hi) begin
          integ_acc   = ctl_lim_hi;
          clamp_state = ClampHigh;
        end else if (cand < ctl_lim_lo) begin
          integ_acc   = ctl_lim_lo;
          clamp_state = ClampLow;
        end else begin
          integ_acc   = cand;
          clamp_state = ClampNone;
        end
      end
      drive = clip_word(mul_q(e, ctl_kp) + integ_acc + mul_q(slope, ctl_kd));
      prev_err = e;
    end else begin
      // Incremental form. The integral term is this step's Ki*e alone and the
      // clamp status is left as it was.
      slope = ctl_flags[FlagDeriv] ? rate_q(e - 2 * prev_err + prev_err2, dt) : 0;
      integ_acc = ctl_flags[FlagInteg] ? clip_word(mul_q(e, ctl_ki)) : 0;
      drive = clip_word(prev_drive + mul_q(e - prev_err, ctl_kp) + integ_acc
                        + mul_q(slope, ctl_kd));
      prev_err2 = prev_err;
      prev_err  = e;
    end
    prev_drive       = drive;
    res.drive_value  = word_t'(drive);
    res.step_invalid = 1'b0;
    res.clamp_status = clamp_state;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Traffic state shared between the stimulus, the driver and the monitor.
  // --------------------------------------------------------------------------
  in_item_t  samples_to_send[$];   // items not yet offered to the block
  out_item_t awaited_drives[$];    // predicted outputs, oldest first
  int        fail_count   = 0;
  bit        bursty       = 1'b1;  // random idling on both sides
  bit        hold_request = 1'b0;  // ask the receiver for one long stall
  int        src_gap      = 0;
  int        sink_gap     = 0;
  int        sink_hold    = 0;
  int        quiet_cycles = 0;
  out_item_t want;

  // Driver: predicts each item as it is accepted, then offers the next one
  // unless a random gap is running. Valid stays up until the handshake.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        awaited_drives.push_back(compute_drive(in_item));
      end
      if (!in_valid || in_ready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_valid <= 1'b0;
        end else if (samples_to_send.size() != 0) begin
          in_item  <= samples_to_send.pop_front();
          in_valid <= 1'b1;
          if (bursty && $urandom_range(0, 4) == 0) src_gap = $urandom_range(1, 6);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted output item against the oldest prediction
  // and drives out_ready with random bursts of back-pressure. A long stall is
  // counted here once the stimulus asks for it.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_drives.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("[%0t] output item with no prediction: drive %0d invalid %0b clamp %0d",
                     $time, out_item.drive_value, out_item.step_invalid,
                     out_item.clamp_status);
          end
        end else begin
          want = awaited_drives.pop_front();
          if (out_item.drive_value !== want.drive_value ||
              out_item.step_invalid !== want.step_invalid ||
              out_item.clamp_status !== want.clamp_status) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("[%0t] mismatch: got drive %0d invalid %0b clamp %0d",
                       $time, out_item.drive_value, out_item.step_invalid,
                       out_item.clamp_status);
              $display("          predicted drive %0d invalid %0b clamp %0d",
                       want.drive_value, want.step_invalid, want.clamp_status);
            end
          end
        end
      end
      if (hold_request) begin
        hold_request = 1'b0;
        sink_hold    = LongHold;
      end
      if (sink_hold > 0) begin
        sink_hold--;
        out_ready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (bursty && $urandom_range(0, 5) == 0) sink_gap = $urandom_range(1, 6);
      end
    end
  end

  // Watchdog: any handshake or register write counts as progress.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic word_t fixq(int num, int den);
    return word_t'((longint'(num) * FracScale) / den);
  endfunction

  function automatic logic [FlagWidth-1:0] flags_of(bit incr, bit deriv, bit integ,
                                                   bit allow);
    logic [FlagWidth-1:0] f;
    f = '0;
    f[FlagIncr]  = incr;
    f[FlagDeriv] = deriv;
    f[FlagInteg] = integ;
    f[FlagAllow] = allow;
    return f;
  endfunction

  function automatic word_t rand_gain();
    case ($urandom_range(0, 9))
      0: return TopWord;
      1: return BottomWord;
      2: return '0;
      3, 4: return word_t'($urandom());
      default: return word_t'($urandom_range(0, 32'h7FFFF)) - 32'sh40000;
    endcase
  endfunction

  function automatic word_t rand_error();
    case ($urandom_range(0, 9))
      0: return TopWord;
      1: return BottomWord;
      2: return '0;
      3, 4: return word_t'($urandom());
      default: return word_t'($urandom_range(0, 32'hFFFFF)) - 32'sh80000;
    endcase
  endfunction

  // Mostly short positive steps, with the odd extreme or invalid one.
  function automatic word_t rand_step();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return word_t'(-1);
      2: return BottomWord;
      3: return word_t'($urandom() | 32'h80000000);
      4: return word_t'(1);
      5: return TopWord;
      6, 7: return word_t'($urandom_range(1, 32'h7FFFFFFF));
      default: return word_t'($urandom_range(1, 32'h40000));
    endcase
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [DataWidth-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    case (idx)
      CfgGainProp:     ctl_kp     = $signed(val);
      CfgGainInteg:    ctl_ki     = $signed(val);
      CfgGainDeriv:    ctl_kd     = $signed(val);
      CfgIntegLimitHi: ctl_lim_hi = $signed(val);
      CfgIntegLimitLo: ctl_lim_lo = $signed(val);
      CfgControlFlags: ctl_flags  = val[FlagWidth-1:0];
      default: ;
    endcase
  endtask

  // Rewrites every register; only called while the block is idle.
  task automatic program_gains(word_t kp, word_t ki, word_t kd, word_t hi, word_t lo,
                               logic [FlagWidth-1:0] fl);
    write_reg(CfgGainProp, kp);
    write_reg(CfgGainInteg, ki);
    write_reg(CfgGainDeriv, kd);
    write_reg(CfgIntegLimitHi, hi);
    write_reg(CfgIntegLimitLo, lo);
    write_reg(CfgControlFlags, {{(DataWidth-FlagWidth){1'b0}}, fl});
    @(posedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send(word_t e, word_t dt);
    samples_to_send.push_back({e, dt});
  endtask

  // Holds the source back until every predicted output has been taken.
  task automatic drain();
    do @(negedge clk);
    while (samples_to_send.size() != 0 || in_valid || awaited_drives.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    word_t kp;
    word_t ki;
    word_t kd;
    word_t hi;
    word_t lo;
    logic [FlagWidth-1:0] fl;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: all gains zero, so the drive stays zero, but invalid
    // steps must still be flagged.
    send(TopWord, word_t'(1));
    send(BottomWord, TopWord);
    send('0, '0);
    send(word_t'(-1), word_t'(-1));
    send(fixq(1, 1), BottomWord);
    drain();

    // Positional form with tight limits: climb into the high clamp, hold the
    // drive over an invalid step, fall into the low clamp, then saturate the
    // derivative rate with a one-LSB time step.
    program_gains(fixq(1, 1), fixq(1, 2), fixq(1, 4), fixq(2, 1), fixq(-2, 1),
                  flags_of(0, 1, 1, 1));
    send(fixq(3, 1), fixq(1, 1));
    send(fixq(3, 1), fixq(1, 1));
    send('0, '0);
    send(fixq(-8, 1), fixq(1, 1));
    send(TopWord, word_t'(1));
    send(BottomWord, TopWord);
    send(BottomWord, word_t'(1));
    drain();

    // Crossed limits with integration on and the derivative off: both clamp
    // tests can hold at once and the high one must win.
    program_gains(TopWord, BottomWord, BottomWord, fixq(-1, 1), fixq(1, 1),
                  flags_of(0, 0, 1, 1));
    send(fixq(1, 1), fixq(1, 1));
    send(fixq(-1, 1), fixq(1, 1));
    send('0, word_t'(1));
    drain();

    // Incremental form at full gains: second difference at its extremes.
    program_gains(fixq(-1, 1), TopWord, TopWord, fixq(1, 1), fixq(-1, 1),
                  flags_of(1, 1, 1, 0));
    send(TopWord, word_t'(1));
    send(BottomWord, word_t'(1));
    send(TopWord, word_t'(1));
    send('0, word_t'(-5));
    send(fixq(2, 1), fixq(1, 2));
    drain();

    // Incremental form with integration allowed but not enabled.
    program_gains(fixq(2, 1), fixq(3, 1), fixq(1, 8), TopWord, BottomWord,
                  flags_of(1, 1, 0, 1));
    send(fixq(1, 1), fixq(1, 4));
    send(fixq(-5, 2), fixq(1, 4));
    send(fixq(7, 1), fixq(2, 1));
    drain();

    // Random phases: a fresh setting per phase, the source pausing between
    // them. Phase 0 and 1 pin the gains and flags at their extremes, phase 2
    // carries the long receiver stall, and the last two run without idling.
    for (int ph = 0; ph < 12; ph++) begin
      kp = rand_gain();
      ki = rand_gain();
      kd = rand_gain();
      case ($urandom_range(0, 3))
        0: begin
          hi = TopWord;
          lo = BottomWord;
        end
        1: begin
          hi = -word_t'($urandom_range(0, 32'h40000));
          lo = word_t'($urandom_range(0, 32'h40000));
        end
        default: begin
          hi = word_t'($urandom_range(0, 32'h100000));
          lo = -word_t'($urandom_range(0, 32'h100000));
        end
      endcase
      fl = FlagWidth'($urandom_range(0, 15));
      if (ph == 0) begin
        kp = TopWord;
        ki = BottomWord;
        kd = TopWord;
        hi = TopWord;
        lo = BottomWord;
        fl = '1;
      end else if (ph == 1) begin
        kp = BottomWord;
        ki = TopWord;
        kd = BottomWord;
        fl = '0;
      end
      bursty = (ph < 10);
      program_gains(kp, ki, kd, hi, lo, fl);
      if (ph == 2) hold_request = 1'b1;
      for (int n = 0; n < 70; n++) send(rand_error(), rand_step());
      drain();
    end

    repeat (80) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
